### rtl/core/plar_pkg.sv
// ----------------------------------------------------------------------------
// plar_pkg
// Types and constants shared by the polyline arc-length resampler core.
// ----------------------------------------------------------------------------
package plar_pkg;

   localparam int POS_W  = 32;
   localparam int TIME_W = 48;
   localparam int CFG_W  = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP       = 1'b1;

   localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RESET = 32'd65536;
   localparam logic [CFG_W-1:0] TIME_STEP_RESET       = 32'd65536;

   // squared distance, root, dividend and quotient widths
   localparam int SQ_W   = 66;
   localparam int ROOT_W = 34;
   localparam int DVD_W  = 65;
   localparam int QUO_W  = 32;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    first_sample;
      logic                    last_sample;
   } plar_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
      logic [TIME_W-1:0]       sample_time;
      logic                    copied_point;
      logic                    truncated;
      logic                    run_last;
   } plar_rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [TIME_W-1:0]       t;
      logic                    copied;
   } plar_ent_type;

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_BASE, S_II, S_IIW, S_DELTA, S_SQX, S_SQY, S_SQZ, S_CHK,
      S_SQRT, S_PX, S_PY, S_PZ, S_PT, S_PD, S_PW, S_DIV, S_STEP, S_FIN, S_END,
      S_RD, S_LD, S_WAIT
   } plar_state_type;

endpackage

### rtl/core/plar_sqrt.sv
// ----------------------------------------------------------------------------
// plar_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module plar_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [plar_pkg::SQ_W-1:0]    radicand,
   output logic                         done,
   output logic [plar_pkg::ROOT_W-1:0]  root
);

   localparam int RAD_W = 2 * plar_pkg::ROOT_W;
   localparam int REM_W = plar_pkg::ROOT_W + 3;

   logic [RAD_W-1:0]            rad_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [plar_pkg::ROOT_W-1:0] root_ff;
   logic [5:0]                  cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [REM_W-1:0] cur;
   logic [REM_W-1:0] trial;
   logic             take;

   assign cur   = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign take  = (cur >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(plar_pkg::ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {{(RAD_W-plar_pkg::SQ_W){1'b0}}, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? (cur - trial) : cur;
         root_ff <= {root_ff[plar_pkg::ROOT_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/core/plar_div.sv
// ----------------------------------------------------------------------------
// plar_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plar_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [plar_pkg::DVD_W-1:0]    dividend,
   input  logic [plar_pkg::ROOT_W-1:0]   divisor,
   output logic                          done,
   output logic [plar_pkg::QUO_W-1:0]    quotient
);

   localparam int REM_W = plar_pkg::ROOT_W + 1;

   logic [plar_pkg::DVD_W-1:0]  dvd_ff;
   logic [plar_pkg::ROOT_W-1:0] dsr_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [plar_pkg::QUO_W-1:0]  q_ff;
   logic [6:0]                  cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [REM_W-1:0] cur;
   logic             take;

   assign cur  = {rem_ff[REM_W-2:0], dvd_ff[plar_pkg::DVD_W-1]};
   assign take = (cur >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(plar_pkg::DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // upper quotient bits are known zero and shift out of q_ff
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[plar_pkg::DVD_W-2:0], 1'b0};
         rem_ff <= take ? (cur - {1'b0, dsr_ff}) : cur;
         q_ff   <= {q_ff[plar_pkg::QUO_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### rtl/core/polyline_arclength_resampler_core.sv
// ----------------------------------------------------------------------------
// polyline_arclength_resampler_core
// Resamples a 3-D stroke to points evenly spaced by arc length.
// ----------------------------------------------------------------------------
// Points enter on the req_ channel (valid/stall); resampled points leave on
// the rsp_ channel, one transfer each, run_last marking the final result of
// an input. csr_ writes set sample_interval (index 0) and time_step
// (index 1); they are to be made only while the block is idle, and the
// block itself does not enforce this. One input is worked at a time;
// req_stall is high until all of its results have been transferred.
// Each interpolated point runs a bit-serial square root, then four parallel
// bit-serial dividers, with steps on the shared 32x32 multiplier.
// Results are buffered per input, because truncated is only known once the
// run ends, then drained through S_RD, S_LD and S_WAIT for each result,
// S_WAIT holding through any rsp_stall; a stalled result holds in the
// output register.
// Synchronous reset restores the register defaults, closes any stroke and
// drops results that were not yet transferred. No clearing pass is needed.
// ----------------------------------------------------------------------------
module polyline_arclength_resampler_core #(
   parameter int MAX_STEPS_PER_INPUT = 63
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  plar_pkg::plar_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output plar_pkg::plar_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [plar_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plar_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int DEPTH = MAX_STEPS_PER_INPUT + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = $clog2(MAX_STEPS_PER_INPUT + 1);
   localparam int PW    = plar_pkg::POS_W;
   localparam int TW    = plar_pkg::TIME_W;

   plar_pkg::plar_state_type state_ff, state_in;

   logic [plar_pkg::CFG_W-1:0] ivl_cfg_ff, ts_ff;
   logic [plar_pkg::CFG_W-1:0] ivl;

   plar_pkg::plar_req_type pt_ff;
   logic signed [PW-1:0] ax_ff, ay_ff, az_ff;
   logic [31:0]          pi_ff;
   logic                 in_stroke_ff;
   logic                 start_ff;
   logic                 cut_ff;
   logic [SW-1:0]        steps_ff;
   logic [CW-1:0]        n_ff;
   logic [CW-1:0]        rd_ptr_ff;

   logic [63:0]          base_ff, ii_ff;
   logic [plar_pkg::SQ_W-1:0] s_ff;
   logic [31:0]          mx_ff, my_ff, mz_ff;
   logic                 sx_ff, sy_ff, sz_ff;
   logic [plar_pkg::ROOT_W-1:0] d_ff;
   logic [plar_pkg::DVD_W-1:0]  dvd_x_ff, dvd_y_ff, dvd_z_ff, dvd_t_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p_ff;

   plar_pkg::plar_ent_type mem [DEPTH];
   plar_pkg::plar_ent_type rd_data_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_wa;
   plar_pkg::plar_ent_type mem_wd;

   plar_pkg::plar_rsp_type rsp_data_ff;
   logic                   rsp_valid_ff;

   logic req_xfer, rsp_xfer;
   logic start_branch;
   logic [plar_pkg::SQ_W-1:0] s_sum;
   logic due;
   logic sq_start, sq_done;
   logic [plar_pkg::ROOT_W-1:0] sq_root;
   logic dv_start;
   logic dx_done, dy_done, dz_done, dt_done;
   logic [plar_pkg::QUO_W-1:0] qx, qy, qz, qt;
   logic signed [32:0] dlt_x, dlt_y, dlt_z;
   logic [32:0] mag_x, mag_y, mag_z;
   logic [64:0] t_sum, end_sum;
   logic [TW-1:0] t_sat, end_time;
   logic [plar_pkg::DVD_W-1:0] dvd_new;

   assign ivl       = (ivl_cfg_ff == '0) ? 32'd1 : ivl_cfg_ff;
   assign req_stall = (state_ff != plar_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign start_branch = req_data.first_sample || !in_stroke_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_cfg_ff <= plar_pkg::SAMPLE_INTERVAL_RESET;
         ts_ff      <= plar_pkg::TIME_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            plar_pkg::CSR_SAMPLE_INTERVAL: ivl_cfg_ff <= csr_wdata;
            plar_pkg::CSR_TIME_STEP:       ts_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier, registered product
   always_comb begin
      mul_a = ivl;
      mul_b = ivl;
      case (state_ff)
         plar_pkg::S_BASE: begin mul_a = pi_ff - 32'd1; mul_b = ts_ff; end
         plar_pkg::S_SQX:  begin mul_a = mx_ff; mul_b = mx_ff; end
         plar_pkg::S_SQY:  begin mul_a = my_ff; mul_b = my_ff; end
         plar_pkg::S_SQZ:  begin mul_a = mz_ff; mul_b = mz_ff; end
         plar_pkg::S_PX:   begin mul_a = mx_ff; mul_b = ivl; end
         plar_pkg::S_PY:   begin mul_a = my_ff; mul_b = ivl; end
         plar_pkg::S_PZ:   begin mul_a = mz_ff; mul_b = ivl; end
         plar_pkg::S_PT:   begin mul_a = ts_ff; mul_b = ivl; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   // anchor to point deltas
   assign dlt_x = {pt_ff.pos_x[PW-1], pt_ff.pos_x} - {ax_ff[PW-1], ax_ff};
   assign dlt_y = {pt_ff.pos_y[PW-1], pt_ff.pos_y} - {ay_ff[PW-1], ay_ff};
   assign dlt_z = {pt_ff.pos_z[PW-1], pt_ff.pos_z} - {az_ff[PW-1], az_ff};
   assign mag_x = dlt_x[32] ? 33'(-dlt_x) : 33'(dlt_x);
   assign mag_y = dlt_y[32] ? 33'(-dlt_y) : 33'(dlt_y);
   assign mag_z = dlt_z[32] ? 33'(-dlt_z) : 33'(dlt_z);

   assign s_sum   = s_ff + {2'b00, mul_p_ff};
   assign due     = (s_sum >= {2'b00, ii_ff});
   assign dvd_new = {1'b0, mul_p_ff} + {{(plar_pkg::DVD_W-plar_pkg::ROOT_W+1){1'b0}},
                                        d_ff[plar_pkg::ROOT_W-1:1]};

   // saturate interpolated and end times
   assign t_sum   = {1'b0, base_ff} + {33'd0, qt};
   assign t_sat   = (t_sum[64:TW] != '0) ? {TW{1'b1}} : t_sum[TW-1:0];
   assign end_sum = {1'b0, base_ff} + {32'd0, ts_ff, 1'b0};
   assign end_time = start_ff ? {16'd0, ts_ff} :
                     ((end_sum[64:TW] != '0) ? {TW{1'b1}} : end_sum[TW-1:0]);

   // sequencer
   always_comb begin
      state_in = state_ff;
      sq_start = 1'b0;
      dv_start = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = n_ff[AW-1:0];
      mem_wd.x = pt_ff.pos_x;
      mem_wd.y = pt_ff.pos_y;
      mem_wd.z = pt_ff.pos_z;
      mem_wd.t = '0;
      mem_wd.copied = 1'b1;
      unique case (state_ff)
         plar_pkg::S_IDLE: begin
            if (req_xfer) state_in = start_branch ? plar_pkg::S_START : plar_pkg::S_BASE;
         end
         plar_pkg::S_START: begin
            mem_we   = 1'b1;
            state_in = pt_ff.last_sample ? plar_pkg::S_END : plar_pkg::S_RD;
         end
         plar_pkg::S_BASE:  state_in = plar_pkg::S_II;
         plar_pkg::S_II:    state_in = plar_pkg::S_IIW;
         plar_pkg::S_IIW:   state_in = plar_pkg::S_DELTA;
         plar_pkg::S_DELTA: state_in = plar_pkg::S_SQX;
         plar_pkg::S_SQX:   state_in = plar_pkg::S_SQY;
         plar_pkg::S_SQY:   state_in = plar_pkg::S_SQZ;
         plar_pkg::S_SQZ:   state_in = plar_pkg::S_CHK;
         plar_pkg::S_CHK: begin
            if (!due || steps_ff == SW'(MAX_STEPS_PER_INPUT)) begin
               state_in = plar_pkg::S_FIN;
            end else begin
               sq_start = 1'b1;
               state_in = plar_pkg::S_SQRT;
            end
         end
         plar_pkg::S_SQRT: if (sq_done) state_in = plar_pkg::S_PX;
         plar_pkg::S_PX:   state_in = plar_pkg::S_PY;
         plar_pkg::S_PY:   state_in = plar_pkg::S_PZ;
         plar_pkg::S_PZ:   state_in = plar_pkg::S_PT;
         plar_pkg::S_PT:   state_in = plar_pkg::S_PD;
         plar_pkg::S_PD:   state_in = plar_pkg::S_PW;
         plar_pkg::S_PW: begin
            dv_start = 1'b1;
            state_in = plar_pkg::S_DIV;
         end
         plar_pkg::S_DIV: begin
            if (dx_done && dy_done && dz_done && dt_done) state_in = plar_pkg::S_STEP;
         end
         plar_pkg::S_STEP: begin
            mem_we   = 1'b1;
            mem_wd.x = sx_ff ? (ax_ff - PW'(qx)) : (ax_ff + PW'(qx));
            mem_wd.y = sy_ff ? (ay_ff - PW'(qy)) : (ay_ff + PW'(qy));
            mem_wd.z = sz_ff ? (az_ff - PW'(qz)) : (az_ff + PW'(qz));
            mem_wd.t = t_sat;
            mem_wd.copied = 1'b0;
            state_in = plar_pkg::S_DELTA;
         end
         plar_pkg::S_FIN: begin
            if (pt_ff.last_sample)  state_in = plar_pkg::S_END;
            else if (n_ff == '0)    state_in = plar_pkg::S_IDLE;
            else                    state_in = plar_pkg::S_RD;
         end
         plar_pkg::S_END: begin
            mem_we   = 1'b1;
            mem_wd.t = end_time;
            state_in = plar_pkg::S_RD;
         end
         plar_pkg::S_RD: state_in = plar_pkg::S_LD;
         plar_pkg::S_LD: state_in = plar_pkg::S_WAIT;
         plar_pkg::S_WAIT: begin
            if (rsp_xfer) begin
               state_in = (rd_ptr_ff == n_ff - CW'(1)) ? plar_pkg::S_IDLE : plar_pkg::S_RD;
            end
         end
         default: state_in = plar_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= plar_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff        <= '0;
         ay_ff        <= '0;
         az_ff        <= '0;
         pi_ff        <= '0;
         in_stroke_ff <= 1'b0;
         start_ff     <= 1'b0;
         cut_ff       <= 1'b0;
         steps_ff     <= '0;
         n_ff         <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_xfer) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            plar_pkg::S_IDLE: begin
               if (req_xfer) begin
                  cut_ff    <= 1'b0;
                  steps_ff  <= '0;
                  n_ff      <= '0;
                  rd_ptr_ff <= '0;
                  start_ff  <= start_branch;
                  if (start_branch) begin
                     ax_ff        <= req_data.pos_x;
                     ay_ff        <= req_data.pos_y;
                     az_ff        <= req_data.pos_z;
                     pi_ff        <= '0;
                     in_stroke_ff <= 1'b1;
                  end else if (pi_ff != '1) begin
                     pi_ff <= pi_ff + 32'd1;
                  end
               end
            end
            plar_pkg::S_START: n_ff <= n_ff + CW'(1);
            plar_pkg::S_CHK: begin
               if (due && steps_ff == SW'(MAX_STEPS_PER_INPUT)) cut_ff <= 1'b1;
            end
            plar_pkg::S_STEP: begin
               ax_ff    <= mem_wd.x;
               ay_ff    <= mem_wd.y;
               az_ff    <= mem_wd.z;
               n_ff     <= n_ff + CW'(1);
               steps_ff <= steps_ff + SW'(1);
            end
            plar_pkg::S_END: begin
               n_ff         <= n_ff + CW'(1);
               in_stroke_ff <= 1'b0;
            end
            plar_pkg::S_LD: rsp_valid_ff <= 1'b1;
            plar_pkg::S_WAIT: if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + CW'(1);
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) pt_ff <= req_data;
      case (state_ff)
         plar_pkg::S_II:  base_ff <= mul_p_ff;
         plar_pkg::S_IIW: ii_ff   <= mul_p_ff;
         plar_pkg::S_DELTA: begin
            mx_ff <= mag_x[31:0];
            my_ff <= mag_y[31:0];
            mz_ff <= mag_z[31:0];
            sx_ff <= dlt_x[32];
            sy_ff <= dlt_y[32];
            sz_ff <= dlt_z[32];
         end
         plar_pkg::S_SQY: s_ff <= {2'b00, mul_p_ff};
         plar_pkg::S_SQZ: s_ff <= s_sum;
         plar_pkg::S_CHK: s_ff <= s_sum;
         plar_pkg::S_SQRT: if (sq_done) d_ff <= sq_root;
         plar_pkg::S_PY:  dvd_x_ff <= dvd_new;
         plar_pkg::S_PZ:  dvd_y_ff <= dvd_new;
         plar_pkg::S_PT:  dvd_z_ff <= dvd_new;
         plar_pkg::S_PD:  dvd_t_ff <= dvd_new;
         plar_pkg::S_LD: begin
            rsp_data_ff.out_x        <= rd_data_ff.x;
            rsp_data_ff.out_y        <= rd_data_ff.y;
            rsp_data_ff.out_z        <= rd_data_ff.z;
            rsp_data_ff.sample_time  <= rd_data_ff.t;
            rsp_data_ff.copied_point <= rd_data_ff.copied;
            rsp_data_ff.truncated    <= cut_ff;
            rsp_data_ff.run_last     <= (rd_ptr_ff == n_ff - CW'(1));
         end
         default: ;
      endcase
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[rd_ptr_ff[AW-1:0]];
   end

   plar_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (s_sum),
      .done     (sq_done),
      .root     (sq_root)
   );

   plar_div u_div_x (
      .clock (clock), .reset (reset), .start (dv_start),
      .dividend (dvd_x_ff), .divisor (d_ff), .done (dx_done), .quotient (qx)
   );

   plar_div u_div_y (
      .clock (clock), .reset (reset), .start (dv_start),
      .dividend (dvd_y_ff), .divisor (d_ff), .done (dy_done), .quotient (qy)
   );

   plar_div u_div_z (
      .clock (clock), .reset (reset), .start (dv_start),
      .dividend (dvd_z_ff), .divisor (d_ff), .done (dz_done), .quotient (qz)
   );

   plar_div u_div_t (
      .clock (clock), .reset (reset), .start (dv_start),
      .dividend (dvd_t_ff), .divisor (d_ff), .done (dt_done), .quotient (qt)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
